/* design/upc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character constants and helper functions for the URL
// percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2b;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChDigit0  = 8'h30;
	localparam logic [7:0] ChAlphaA  = 8'h57;

	localparam logic [0:0] RegCodecMode = 1'b0;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} codec_mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      cnt;
		logic            last;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		case (c) inside
			[8'h30:8'h39]: begin
				h.valid = 1'b1;
				h.value = c[3:0];
			end
			[8'h41:8'h46], [8'h61:8'h66]: begin
				h.valid = 1'b1;
				h.value = c[3:0] + 4'd9;
			end
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic logic is_unreserved(input logic [7:0] c);
		logic r;
		case (c) inside
			[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
			8'h2d, 8'h5f, 8'h2e, 8'h7e: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = ChDigit0 + {4'b0, n};
		end else begin
			r = ChAlphaA + {4'b0, n};
		end
		return r;
	endfunction

endpackage

/* design/upc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_front
// Accepts source bytes, tracks the escape state and turns each byte into a
// job of up to three output bytes.
// ----------------------------------------------------------------------------
module upc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  upc_pkg::codec_mode_t mode,
	input  logic                 clr,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 push,
	output upc_pkg::job_t        push_job
);

	upc_pkg::esc_phase_t phase_q, phase_d;
	logic [7:0]          held_q;
	upc_pkg::hex_t       hv_in, hv_held;
	logic                accept;
	logic [7:0]          idle_byte;
	logic                idle_emit;
	logic                idle_esc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign hv_in    = upc_pkg::hex_decode(in_byte);
	assign hv_held  = upc_pkg::hex_decode(held_q);
	assign push     = accept && (push_job.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upc_pkg::PH_IDLE;
		end else if (clr) begin
			phase_q <= upc_pkg::PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_d == upc_pkg::PH_DIGIT) begin
			held_q <= in_byte;
		end
	end

	always_comb begin
		// byte handled as if no escape were open
		idle_byte = in_byte;
		idle_emit = 1'b1;
		idle_esc  = 1'b0;
		if (in_byte == upc_pkg::ChPercent) begin
			idle_emit = in_last;
			idle_esc  = !in_last;
		end else if (in_byte == upc_pkg::ChPlus) begin
			idle_byte = upc_pkg::ChSpace;
		end

		push_job      = '0;
		push_job.last = in_last;
		phase_d       = upc_pkg::PH_IDLE;

		if (mode == upc_pkg::MODE_ENCODE) begin
			if (upc_pkg::is_unreserved(in_byte)) begin
				push_job.data[0] = in_byte;
				push_job.cnt     = 2'd1;
			end else begin
				push_job.data[0] = upc_pkg::ChPercent;
				push_job.data[1] = upc_pkg::hex_char(in_byte[7:4]);
				push_job.data[2] = upc_pkg::hex_char(in_byte[3:0]);
				push_job.cnt     = 2'd3;
			end
		end else begin
			case (phase_q)
				upc_pkg::PH_IDLE: begin
					push_job.data[0] = idle_byte;
					push_job.cnt     = {1'b0, idle_emit};
					if (idle_esc) phase_d = upc_pkg::PH_PCT;
				end
				upc_pkg::PH_PCT: begin
					if (hv_in.valid && !in_last) begin
						phase_d = upc_pkg::PH_DIGIT;
					end else if (hv_in.valid) begin
						push_job.data[0] = upc_pkg::ChPercent;
						push_job.data[1] = in_byte;
						push_job.cnt     = 2'd2;
					end else begin
						push_job.data[0] = upc_pkg::ChPercent;
						push_job.data[1] = idle_byte;
						push_job.cnt     = 2'd1 + {1'b0, idle_emit};
						if (idle_esc) phase_d = upc_pkg::PH_PCT;
					end
				end
				upc_pkg::PH_DIGIT: begin
					if (hv_in.valid && hv_held.valid) begin
						push_job.data[0] = {hv_held.value, hv_in.value};
						push_job.cnt     = 2'd1;
					end else begin
						push_job.data[0] = upc_pkg::ChPercent;
						push_job.data[1] = held_q;
						push_job.data[2] = idle_byte;
						push_job.cnt     = 2'd2 + {1'b0, idle_emit};
						if (idle_esc) phase_d = upc_pkg::PH_PCT;
					end
				end
				default: begin
					phase_d = upc_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/upc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_queue
// Small job queue that decouples the classifying front from the output
// serializer.
// ----------------------------------------------------------------------------
module upc_queue #(
	parameter int unsigned DEPTH = upc_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output upc_pkg::job_t head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	upc_pkg::job_t   mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/upc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_back
// Serializes queued jobs into single output bytes through an output
// register.
// ----------------------------------------------------------------------------
module upc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  upc_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       job_end;

	assign load      = !empty && (!out_valid_q || !out_stall);
	assign job_end   = (idx_q == head.cnt - 2'd1);
	assign pop       = load && job_end;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= job_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.data[idx_q];
			out_last_q <= head.last && job_end;
		end
	end

endmodule

/* design/url_percent_codec_unit.sv */
`timescale 1ns / 1ps
// the first output byte of an input passes through the job queue and the output register
// throughput: one output byte per cycle from the serializer unless stalled; an
//   input byte yields 0 to 3 output bytes (3 for an escaped byte in encode mode
//   or a broken escape with a held digit in decode mode, 0 for a byte held in
//   an escape); inputs keep flowing while the job queue has room
// reset: asynchronous, clears mode to encode, escape state and queue
// ----------------------------------------------------------------------------
// url_percent_codec_unit
// Streaming URL percent encoder and decoder with an APB mode register.
// ----------------------------------------------------------------------------
module url_percent_codec_unit #(
	parameter int unsigned QUEUE_DEPTH = upc_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	upc_pkg::codec_mode_t mode_q;
	logic                 cfg_wr;
	logic                 reg_hit;
	logic                 push, pop, q_full, q_empty;
	upc_pkg::job_t        push_job, head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == upc_pkg::RegCodecMode) && (paddr[1:0] == 2'b00);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? {31'b0, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= upc_pkg::MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= upc_pkg::codec_mode_t'(pwdata[0]);
		end
	end

	upc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.clr      (cfg_wr),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	upc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	upc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

/* design/upc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_checker
// Port-level checks for the URL percent codec, bound to the top level.
// ----------------------------------------------------------------------------
module upc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  in_byte,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        out_last
);

	logic mode_wr;
	logic mode_rd;

	assign mode_wr = psel && penable && pwrite && pready && (paddr == 3'b000);
	assign mode_rd = psel && !pwrite && (paddr == 3'b000);

	// stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output changed while stalled");

	// stalled input transfer holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("input changed while stalled");

	// mode register reads back what was written
	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		mode_wr ##1 mode_rd |-> prdata[0] == $past(pwdata[0]))
		else $error("mode readback mismatch");

	// only the mode bit is ever returned
	a_rd_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[31:1] == '0)
		else $error("unused read bits set");

	// no output byte can appear right out of reset
	a_no_out_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind url_percent_codec_unit upc_checker u_upc_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for url_percent_codec_unit. A byte-level predictor
// tracks the mode register and the held escape sequence. It queues the
// bytes that each accepted source byte should produce, and every output
// transfer is checked against the oldest one. Directed strings cover the
// character classes, valid, invalid and cut-short escapes, and a mode write
// in the middle of an escape. Random strings follow in alternating modes,
// with random stalls on both sides, a long output hold-off and a stretch
// with no stalls at all.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [2:0] AddrCodecMode = 3'd0;
	localparam logic [2:0] AddrUnused    = 3'd4;
	localparam int DrainCycles   = 8;
	localparam int StallLimit    = 2000;
	localparam int PhaseBytes    = 22;
	localparam int LongHoldCycles = 80;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} codec_byte_t;

	function automatic logic passes_unescaped(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a) || c == 8'h2d || c == 8'h5f ||
			c == 8'h2e || c == 8'h7e;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			return 5'b0;
		end
		return {1'b1, v[3:0]};
	endfunction

	function automatic logic [7:0] lower_hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
	endfunction

	class percent_scoreboard;
		upc_pkg::codec_mode_t mode;
		upc_pkg::esc_phase_t  phase;
		logic [7:0]           held;
		codec_byte_t          expected_bytes[$];
		int                   errors;

		function new();
			mode   = upc_pkg::MODE_ENCODE;
			phase  = upc_pkg::PH_IDLE;
			held   = '0;
			errors = 0;
		endfunction

		function void write_register(input int idx, input logic [31:0] value);
			if (idx == int'(upc_pkg::RegCodecMode)) begin
				mode  = upc_pkg::codec_mode_t'(value[0]);
				phase = upc_pkg::PH_IDLE;
				held  = '0;
			end
		endfunction

		function void push_byte(input logic [7:0] b);
			expected_bytes.push_back({b, 1'b0});
		endfunction

		function void decode_plain(input logic [7:0] b, input logic l);
			if (b == upc_pkg::ChPercent) begin
				if (l) begin
					push_byte(upc_pkg::ChPercent);
				end else begin
					phase = upc_pkg::PH_PCT;
				end
			end else if (b == upc_pkg::ChPlus) begin
				push_byte(upc_pkg::ChSpace);
			end else begin
				push_byte(b);
			end
		endfunction

		function void take_source_byte(input logic [7:0] b, input logic l);
			int                  first;
			upc_pkg::esc_phase_t prior;
			logic [4:0]          cur;
			logic [4:0]          hi;
			codec_byte_t         tail;
			first = expected_bytes.size();
			prior = phase;
			phase = upc_pkg::PH_IDLE;
			if (mode == upc_pkg::MODE_ENCODE) begin
				held = '0;
				if (passes_unescaped(b)) begin
					push_byte(b);
				end else begin
					push_byte(upc_pkg::ChPercent);
					push_byte(lower_hex_char(b[7:4]));
					push_byte(lower_hex_char(b[3:0]));
				end
			end else begin
				cur = hex_digit_value(b);
				case (prior)
					upc_pkg::PH_IDLE: begin
						decode_plain(b, l);
					end
					upc_pkg::PH_PCT: begin
						if (cur[4] && !l) begin
							held  = b;
							phase = upc_pkg::PH_DIGIT;
						end else if (cur[4]) begin
							push_byte(upc_pkg::ChPercent);
							push_byte(b);
						end else begin
							push_byte(upc_pkg::ChPercent);
							decode_plain(b, l);
						end
					end
					default: begin
						hi = hex_digit_value(held);
						if (cur[4] && hi[4]) begin
							push_byte({hi[3:0], cur[3:0]});
						end else begin
							push_byte(upc_pkg::ChPercent);
							push_byte(held);
							decode_plain(b, l);
						end
					end
				endcase
				if (phase != upc_pkg::PH_DIGIT) held = '0;
				if (l) begin
					phase = upc_pkg::PH_IDLE;
					held  = '0;
				end
			end
			if (l && expected_bytes.size() > first) begin
				tail = expected_bytes.pop_back();
				tail.last = 1'b1;
				expected_bytes.push_back(tail);
			end
		endfunction

		function void check_output_byte(input logic [7:0] b, input logic l);
			codec_byte_t want;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output byte %h last %b", $time, b, l);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (want.data !== b) begin
				$display("%0t: out_byte expected %h got %h", $time, want.data, b);
				errors++;
			end
			if (want.last !== l) begin
				$display("%0t: out_last expected %b got %b", $time, want.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        out_last;

	percent_scoreboard sb;
	logic [7:0] text[$];
	bit  steady = 1'b0;
	int  rx_hold = 0;
	int  sent_bytes = 0;
	int  quiet_cycles = 0;

	url_percent_codec_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_output_byte(out_byte, out_last);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= StallLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, StallLimit);
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 9);
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d,
			output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		if (wr) sb.write_register(int'(a >> 2), d);
	endtask

	task automatic read_mode_and_release();
		logic [31:0] rd;
		apb_access(1'b0, AddrCodecMode, '0, rd);
		if (rd[0] !== sb.mode) begin
			$display("%0t: codec_mode expected %b got %b", $time, sb.mode, rd[0]);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_mode(input upc_pkg::codec_mode_t m);
		logic [31:0] rd;
		apb_access(1'b1, AddrCodecMode, {31'($urandom), m}, rd);
		read_mode_and_release();
	endtask

	task automatic send_item(input logic [7:0] b, input logic l);
		while (!steady && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.take_source_byte(b, l);
		sent_bytes++;
	endtask

	task automatic send_text();
		foreach (text[i]) send_item(text[i], i == text.size() - 1);
		text.delete();
	endtask

	task automatic load_text(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex_char();
		logic [3:0] n;
		n = 4'($urandom);
		if (n < 4'd10) return 8'h30 + 8'(n);
		if ($urandom_range(0, 1)) return 8'h41 + 8'(n) - 8'd10;
		return 8'h61 + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] b;
		logic [4:0] h;
		do begin
			b = 8'($urandom);
			h = hex_digit_value(b);
		end while (h[4]);
		return b;
	endfunction

	task automatic add_decode_token();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				text.push_back(upc_pkg::ChPercent);
				text.push_back(rand_hex_char());
				text.push_back(rand_hex_char());
			end
			4: text.push_back(upc_pkg::ChPlus);
			5, 6: text.push_back(8'h61 + 8'($urandom_range(0, 25)));
			7: text.push_back(8'($urandom));
			8: begin
				text.push_back(upc_pkg::ChPercent);
				if ($urandom_range(0, 1)) text.push_back(rand_hex_char());
				text.push_back(rand_non_hex());
			end
			default: text.push_back(upc_pkg::ChPercent);
		endcase
	endtask

	initial begin
		logic [31:0] rd;
		int          goal;
		sb       = new();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		in_byte  = '0;
		in_last  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write to an unmapped address must leave encode mode in place
		apb_access(1'b1, AddrUnused, '1, rd);
		read_mode_and_release();
		load_text("Az0~-.%+");
		text.push_front(8'hff);
		text.push_front(8'h00);
		send_text();
		wait_drain();

		write_mode(upc_pkg::MODE_DECODE);
		load_text("%4a%Ff+%g%4z%");
		send_text();
		load_text("%4");
		send_text();
		// escape held across a mode write is dropped
		send_item(upc_pkg::ChPercent, 1'b0);
		send_item(8'h34, 1'b0);
		wait_drain();
		write_mode(upc_pkg::MODE_DECODE);
		send_item(8'h31, 1'b1);

		for (int p = 0; p < 6; p++) begin
			wait_drain();
			write_mode(p % 2 ? upc_pkg::MODE_DECODE : upc_pkg::MODE_ENCODE);
			if (p == 2) rx_hold = LongHoldCycles;
			steady = (p == 3);
			goal = sent_bytes + PhaseBytes;
			while (sent_bytes < goal) begin
				if (sb.mode == upc_pkg::MODE_DECODE) begin
					repeat ($urandom_range(1, 4)) add_decode_token();
				end else begin
					repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
				end
				send_text();
			end
			steady = 1'b0;
		end

		wait_drain();
		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
